// ===== sv/sssd_pkg.sv =====
// Package for the seven-segment scan driver: widths, operation codes, glyph and LED tables.
`default_nettype none
package sssd_pkg;

  localparam int DIGIT_COUNT_DEF = 6;
  localparam int PWM_STEPS_DEF   = 8;

  localparam int OP_W     = 2;
  localparam int POS_W    = 3;
  localparam int CHAR_W   = 8;
  localparam int LED_W    = 13;
  localparam int SEG_W    = 8;
  localparam int GLYPH_W  = 7;
  localparam int BRIGHT_W = 3;

  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
  localparam logic [OP_W-1:0] OP_COMMIT = 2'd2;

  // LED bit position of the dot of digit 1; digits 1 to 4 follow it
  localparam int LED_DOT_BASE  = 8;
  // LED bit position of the dot of digit 0
  localparam int LED_DOT_ZERO  = 12;
  // digits 0 to DOT_DIGITS-1 take their dot from the LED dot bits
  localparam int DOT_DIGITS    = 5;
  localparam int DOT_BIT       = 7;

  localparam logic [GLYPH_W-1:0] GLYPH_UNDERSCORE = 7'h08;

  // segment bit driven by each of LED bits 0..7
  localparam int LED_SEG_BIT [8] = '{0, 1, 5, 6, 3, 2, 4, 7};

  // Map an ASCII code to segments a..g (bits 6..0); unknown codes give underscore.
  function automatic logic [GLYPH_W-1:0] glyph(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] lc;
    logic [GLYPH_W-1:0] g;
    lc = (c >= 8'h41 && c <= 8'h5a) ? (c | 8'h20) : c;
    case (c)
      8'h30: g = 7'h7e;
      8'h31: g = 7'h30;
      8'h32: g = 7'h6d;
      8'h33: g = 7'h79;
      8'h34: g = 7'h33;
      8'h35: g = 7'h5b;
      8'h36: g = 7'h5f;
      8'h37: g = 7'h70;
      8'h38: g = 7'h7f;
      8'h39: g = 7'h7b;
      8'h43: g = 7'h4e; // C
      8'h63: g = 7'h0d; // c
      8'h48: g = 7'h57; // H
      8'h68: g = 7'h37; // h
      8'h6f: g = 7'h1d; // o
      8'h4f: g = 7'h7e; // O
      default: begin
        case (lc)
          8'h61: g = 7'h77;
          8'h62: g = 7'h1f;
          8'h64: g = 7'h3d;
          8'h65: g = 7'h4f;
          8'h66: g = 7'h47;
          8'h67: g = 7'h5e;
          8'h6a: g = 7'h7c;
          8'h70: g = 7'h67;
          8'h2d: g = 7'h01; // minus
          8'h6e: g = 7'h15;
          8'h74: g = 7'h0f;
          8'h20: g = 7'h00; // blank
          8'h72: g = 7'h05;
          8'h75: g = 7'h1c;
          8'h6c: g = 7'h0e;
          default: g = GLYPH_UNDERSCORE;
        endcase
      end
    endcase
    return g;
  endfunction

  // Scatter LED bits 0..7 onto the segment bits of the last digit.
  function automatic logic [SEG_W-1:0] led_segments(input logic [7:0] leds);
    logic [SEG_W-1:0] s;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s[LED_SEG_BIT[i]] = leds[i];
    end
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== sv/sssd_if.sv =====
// Valid/ready channel interfaces for the scan driver's item and result beats.
`default_nettype none
interface sssd_in_if;
  logic                          valid;
  logic                          ready;
  logic [sssd_pkg::OP_W-1:0]     operation;
  logic [sssd_pkg::POS_W-1:0]    position;
  logic [sssd_pkg::CHAR_W-1:0]   character;
  logic [sssd_pkg::LED_W-1:0]    led_bits;

  modport source (output valid, operation, position, character, led_bits, input ready);
  modport sink   (input valid, operation, position, character, led_bits, output ready);
endinterface

interface sssd_out_if #(
  parameter int ANODE_W = sssd_pkg::DIGIT_COUNT_DEF
);
  logic                        valid;
  logic                        ready;
  logic [ANODE_W-1:0]          anode_drive;
  logic [sssd_pkg::SEG_W-1:0]  segment_drive;
  logic                        frame_pending;

  modport source (output valid, anode_drive, segment_drive, frame_pending, input ready);
  modport sink   (input valid, anode_drive, segment_drive, frame_pending, output ready);
endinterface
`default_nettype wire

// ===== sv/seven_segment_scan_driver.sv =====
// Multiplexed seven-segment scan driver with PWM brightness and a double-buffered frame.
`default_nettype none
// Takes one item per clock: a tick, a character write or a commit. Every item yields one
// result beat in the cycle after acceptance, held in the output stage until taken; a new
// item is taken in the same cycle the waiting beat leaves, so the block sustains one item
// per cycle and stalls only while the result side holds ready low. The two frames live in
// one single-port memory of 2**AW seven-bit glyph entries (one read or one write per item,
// read data registered); the decimal points and per-entry valid bits sit in flops, so no
// clearing pass is needed after reset and an unwritten entry reads as blank. A tick
// advances the PWM phase; after PWM_STEPS ticks the scan moves to the next digit, swaps
// frames if a commit is pending and reads that digit's glyph. The anode stays lit for
// brightness+1 phases of each slot. The first slot after reset is dark.
module seven_segment_scan_driver #(
  parameter int DIGIT_COUNT = sssd_pkg::DIGIT_COUNT_DEF,
  parameter int PWM_STEPS   = sssd_pkg::PWM_STEPS_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             cfg_we,
  input  wire [sssd_pkg::BRIGHT_W-1:0]    cfg_wdata,
  sssd_in_if.sink                         in_ch,
  sssd_out_if.source                      out_ch
);

  localparam int DW     = $clog2(DIGIT_COUNT);
  localparam int AW     = DW + 1;
  localparam int DEPTH  = 2 ** AW;
  localparam int PW     = $clog2(PWM_STEPS + 1);
  localparam int CMP_W  = (PW > sssd_pkg::BRIGHT_W) ? PW : sssd_pkg::BRIGHT_W;
  localparam int GW     = sssd_pkg::GLYPH_W;
  localparam logic [DW-1:0] LAST_DIGIT = DW'(DIGIT_COUNT - 1);

  // control state
  logic [sssd_pkg::BRIGHT_W-1:0] bright_r;
  logic [PW-1:0]                 phase_r, phase_nxt;
  logic [DW-1:0]                 digit_r, digit_nxt;
  logic                          sel_r, sel_nxt;      // 0: frame a shown, b staging
  logic                          pend_r, pend_nxt;
  logic [DIGIT_COUNT-1:0]        anode_r, anode_nxt;
  logic                          out_valid_r;
  logic                          load_r;              // last item reloaded the segments
  logic [sssd_pkg::SEG_W-1:0]    seg_hold_r;

  // frame storage
  logic [GW-1:0]                 mem [DEPTH];
  logic [DEPTH-1:0]              valid_r;
  logic [DEPTH-1:0]              dot_r, dot_nxt;
  logic [GW-1:0]                 rd_data_r;
  logic                          rd_ok_r;
  logic                          rd_dot_r;

  logic                          accept;
  logic                          is_tick, is_write, is_commit;
  logic                          wrap;
  logic                          stg;
  logic                          pos_ok;
  logic [AW-1:0]                 rd_addr;
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  logic [GW-1:0]                 wr_data;
  logic [sssd_pkg::SEG_W-1:0]    led_seg;
  logic [sssd_pkg::SEG_W-1:0]    seg_cur;

  // the waiting beat leaves in the cycle the next item comes in
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign is_tick   = accept && (in_ch.operation == sssd_pkg::OP_TICK);
  assign is_write  = accept && (in_ch.operation == sssd_pkg::OP_WRITE);
  assign is_commit = accept && (in_ch.operation == sssd_pkg::OP_COMMIT);
  assign wrap      = is_tick && (phase_r >= PW'(PWM_STEPS));
  assign stg       = ~sel_r;
  assign pos_ok    = int'(in_ch.position) < DIGIT_COUNT - 1;
  assign led_seg   = sssd_pkg::led_segments(in_ch.led_bits[7:0]);

  // scan and PWM control
  always_comb begin
    phase_nxt = phase_r;
    digit_nxt = digit_r;
    sel_nxt   = sel_r;
    pend_nxt  = pend_r;
    anode_nxt = anode_r;
    if (is_tick) begin
      if (wrap) begin
        // advance to the next digit, swap in a pending frame, light its anode
        digit_nxt = (digit_r == LAST_DIGIT) ? '0 : DW'(digit_r + 1'b1);
        sel_nxt   = sel_r ^ pend_r;
        pend_nxt  = 1'b0;
        anode_nxt = {{(DIGIT_COUNT-1){1'b0}}, 1'b1} << digit_nxt;
        phase_nxt = '0;
      end
      // drop the anode once the phase passes the brightness setting
      if (CMP_W'(phase_nxt) > CMP_W'(bright_r)) begin
        anode_nxt = '0;
      end
      phase_nxt = PW'(phase_nxt + 1'b1);
    end else if (is_commit) begin
      pend_nxt = 1'b1;
    end
  end

  assign rd_addr = {sel_nxt, digit_nxt};

  // one memory write per item: a character write or the last digit of a commit
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {stg, LAST_DIGIT};
    wr_data = led_seg[GW-1:0];
    if (is_write && pos_ok) begin
      wr_en   = 1'b1;
      wr_addr = {stg, in_ch.position[DW-1:0]};
      wr_data = sssd_pkg::glyph(in_ch.character);
    end else if (is_commit) begin
      wr_en   = 1'b1;
    end
  end

  // decimal points of the staging frame
  always_comb begin
    logic [AW-1:0] idx;
    dot_nxt = dot_r;
    idx     = '0;
    if (is_write && pos_ok) begin
      dot_nxt[{stg, in_ch.position[DW-1:0]}] = 1'b0;
    end else if (is_commit) begin
      for (int d = 0; d < DIGIT_COUNT; d++) begin
        idx = {stg, DW'(d)};
        if (d == 0) begin
          dot_nxt[idx] = in_ch.led_bits[sssd_pkg::LED_DOT_ZERO];
        end else if (d < sssd_pkg::DOT_DIGITS) begin
          dot_nxt[idx] = in_ch.led_bits[sssd_pkg::LED_DOT_BASE + d - 1];
        end else if (d == DIGIT_COUNT - 1) begin
          dot_nxt[idx] = led_seg[sssd_pkg::DOT_BIT];
        end
      end
    end
  end

  // glyph memory: written and read in clocked blocks, one access per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wrap) begin
      rd_data_r <= mem[rd_addr];
      rd_ok_r   <= valid_r[rd_addr];
      rd_dot_r  <= dot_r[rd_addr];
    end
  end

  // segment lines: the fresh read after a reload, else the held pattern
  assign seg_cur = load_r ? {rd_dot_r, rd_ok_r ? rd_data_r : {GW{1'b0}}} : seg_hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_r    <= '0;
      phase_r     <= '0;
      digit_r     <= '0;
      sel_r       <= 1'b0;
      pend_r      <= 1'b0;
      anode_r     <= '0;
      out_valid_r <= 1'b0;
      load_r      <= 1'b0;
      seg_hold_r  <= '0;
      valid_r     <= '0;
      dot_r       <= '0;
    end else begin
      if (cfg_we) begin
        bright_r <= cfg_wdata;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
        seg_hold_r  <= seg_cur;
        load_r      <= wrap;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      phase_r <= phase_nxt;
      digit_r <= digit_nxt;
      sel_r   <= sel_nxt;
      pend_r  <= pend_nxt;
      anode_r <= anode_nxt;
      dot_r   <= dot_nxt;
    end
  end

  // the result beat shows the line state left by the last item
  assign out_ch.valid         = out_valid_r;
  assign out_ch.anode_drive   = anode_r;
  assign out_ch.segment_drive = seg_cur;
  assign out_ch.frame_pending = pend_r;

  a_beat_after_item: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("item accepted without a result beat");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(anode_r) && $stable(pend_r)))
    else $error("result changed while stalled");

  a_commit_pending: assert property (@(posedge clk) disable iff (!rst_n)
    is_commit |=> pend_r)
    else $error("commit did not mark the frame pending");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PW'(PWM_STEPS))
    else $error("PWM phase out of range");

  a_anode_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (anode_r == '0) || (anode_r == ({{(DIGIT_COUNT-1){1'b0}}, 1'b1} << digit_r)))
    else $error("lit anode does not match the scanned digit");

endmodule
`default_nettype wire

// ===== tb/seven_segment_scan_driver_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the seven-segment scan driver: directed table, then random beats.
module seven_segment_scan_driver_tb;

  localparam int NDIG = sssd_pkg::DIGIT_COUNT_DEF;
  localparam int NPWM = sssd_pkg::PWM_STEPS_DEF;
  localparam int OP_W     = sssd_pkg::OP_W;
  localparam int POS_W    = sssd_pkg::POS_W;
  localparam int CHAR_W   = sssd_pkg::CHAR_W;
  localparam int LED_W    = sssd_pkg::LED_W;
  localparam int SEG_W    = sssd_pkg::SEG_W;
  localparam int BRIGHT_W = sssd_pkg::BRIGHT_W;
  localparam logic [OP_W-1:0] OP_TICK   = sssd_pkg::OP_TICK;
  localparam logic [OP_W-1:0] OP_WRITE  = sssd_pkg::OP_WRITE;
  localparam logic [OP_W-1:0] OP_COMMIT = sssd_pkg::OP_COMMIT;
  // operation code 3 is not defined by the block: it must leave the state alone
  localparam logic [OP_W-1:0] OP_NOP = 2'd3;
  localparam int DP_BIT = 7;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 292;
  // brightness per random phase; both extremes are in the list
  localparam int BRIGHT_PLAN [PHASES] = '{7, 3, 0, 5, 1, 6};
  // segment bit set by each of LED bits 0..7 on the last digit
  localparam int LED_TO_SEG [8] = '{0, 1, 5, 6, 3, 2, 4, 7};

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  pos;
    logic [CHAR_W-1:0] ch;
    logic [LED_W-1:0]  leds;
  } scan_item_t;

  typedef struct packed {
    logic [NDIG-1:0]  anode;
    logic [SEG_W-1:0] seg;
    logic             pending;
  } scan_beat_t;

  // one line of the directed table; pinned rows carry a hand-typed result
  typedef struct packed {
    scan_item_t item;
    logic [7:0] reps;
    logic       pinned;
    scan_beat_t want;
  } drill_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [BRIGHT_W-1:0] cfg_wdata;

  sssd_in_if in_ch();
  sssd_out_if #(.ANODE_W(NDIG)) out_ch();

  seven_segment_scan_driver dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Scan model state: two frames, which one is shown, PWM phase and the driven lines.
  logic [SEG_W-1:0]    frame_a [NDIG] = '{default: '0};
  logic [SEG_W-1:0]    frame_b [NDIG] = '{default: '0};
  logic                showing_b = 1'b0;
  logic                swap_armed = 1'b0;
  int                  pwm_q = 0;
  int                  digit_q = 0;
  logic [NDIG-1:0]     anode_q = '0;
  logic [SEG_W-1:0]    seg_q = '0;
  logic [BRIGHT_W-1:0] bright_q = '0;

  // result beats owed by the block, oldest first
  scan_beat_t beats_due[$];

  // hand-typed result for the beat currently offered, set together with the beat
  logic       pin_now;
  scan_beat_t pin_beat;

  int send_idle;
  int recv_idle;

  int n_ticks = 0, n_writes = 0, n_commits = 0, n_nops = 0;
  int n_checked = 0, n_swaps = 0, n_slots = 0, n_errors = 0;

  string glyph_chars = "0123456789CcHhoOaAbBdDeEfFgGjJpP-nNtT rRuUlLzZ?.";

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ASCII to segments a..g; anything without a pattern shows an underscore.
  function automatic logic [6:0] char_segments(input logic [7:0] c);
    logic [7:0] folded;
    logic [6:0] pat;
    folded = c;
    pat = 7'h08;
    case (c)
      "0": pat = 7'h7e;
      "1": pat = 7'h30;
      "2": pat = 7'h6d;
      "3": pat = 7'h79;
      "4": pat = 7'h33;
      "5": pat = 7'h5b;
      "6": pat = 7'h5f;
      "7": pat = 7'h70;
      "8": pat = 7'h7f;
      "9": pat = 7'h7b;
      "C": pat = 7'h4e;
      "c": pat = 7'h0d;
      "H": pat = 7'h57;
      "h": pat = 7'h37;
      "o": pat = 7'h1d;
      "O": pat = 7'h7e;
      default: begin
        // fold the remaining capitals onto lower case before the letter lookup
        if (c >= "A" && c <= "Z") folded = c + 8'h20;
        case (folded)
          "a": pat = 7'h77;
          "b": pat = 7'h1f;
          "d": pat = 7'h3d;
          "e": pat = 7'h4f;
          "f": pat = 7'h47;
          "g": pat = 7'h5e;
          "j": pat = 7'h7c;
          "p": pat = 7'h67;
          "-": pat = 7'h01;
          "n": pat = 7'h15;
          "t": pat = 7'h0f;
          " ": pat = 7'h00;
          "r": pat = 7'h05;
          "u": pat = 7'h1c;
          "l": pat = 7'h0e;
          default: pat = 7'h08;
        endcase
      end
    endcase
    return pat;
  endfunction

  // Set or clear one bit of a digit in the frame that is not on display.
  task automatic stage_bit(input int digit, input int bitpos, input logic on);
    if (showing_b) frame_a[digit][bitpos] = on;
    else frame_b[digit][bitpos] = on;
  endtask

  // Advance the scan model by one beat and return the lines it drives afterwards.
  task automatic scan_step(input scan_item_t it, output scan_beat_t res);
    logic [SEG_W-1:0] pat;
    pat = '0;
    case (it.op)
      OP_TICK: begin
        // slot over: move to the next digit, swap a pending frame in, light the anode
        if (pwm_q >= NPWM) begin
          digit_q = (digit_q + 1 >= NDIG) ? 0 : digit_q + 1;
          if (swap_armed) begin
            showing_b = ~showing_b;
            swap_armed = 1'b0;
            n_swaps++;
          end
          seg_q = showing_b ? frame_b[digit_q] : frame_a[digit_q];
          anode_q = '0;
          anode_q[digit_q] = 1'b1;
          pwm_q = 0;
          n_slots++;
        end
        // go dark once the phase passes the brightness setting
        if (pwm_q > int'(bright_q)) anode_q = '0;
        pwm_q++;
      end
      OP_WRITE: begin
        // the last digit belongs to the LED bits; writes beyond the text digits drop
        if (int'(it.pos) < NDIG - 1) begin
          pat = {1'b0, char_segments(it.ch)};
          if (showing_b) frame_a[it.pos] = pat;
          else frame_b[it.pos] = pat;
        end
      end
      OP_COMMIT: begin
        for (int i = 0; i < 8; i++) stage_bit(NDIG - 1, LED_TO_SEG[i], it.leds[i]);
        for (int i = 0; i < 4; i++) stage_bit(i + 1, DP_BIT, it.leds[8 + i]);
        stage_bit(0, DP_BIT, it.leds[12]);
        swap_armed = 1'b1;
      end
      default: ;
    endcase
    res.anode = anode_q;
    res.seg = seg_q;
    res.pending = swap_armed;
  endtask

  // Sample both channels at the rising edge: retire result beats first, then log new beats.
  always @(posedge clk) begin : watch
    scan_item_t acc;
    scan_beat_t got;
    scan_beat_t want;
    scan_beat_t res;
    if (rst_n) begin
      if (cfg_we) bright_q = cfg_wdata;
      if (out_ch.valid && out_ch.ready) begin
        got.anode = out_ch.anode_drive;
        got.seg = out_ch.segment_drive;
        got.pending = out_ch.frame_pending;
        if (beats_due.size() == 0) begin
          $error("result beat with nothing expected: anode_drive %h segment_drive %h",
                 got.anode, got.seg);
          n_errors++;
        end else begin
          want = beats_due.pop_front();
          n_checked++;
          if (got.anode !== want.anode) begin
            $error("anode_drive: expected %h, got %h", want.anode, got.anode);
            n_errors++;
          end
          if (got.seg !== want.seg) begin
            $error("segment_drive: expected %h, got %h", want.seg, got.seg);
            n_errors++;
          end
          if (got.pending !== want.pending) begin
            $error("frame_pending: expected %b, got %b", want.pending, got.pending);
            n_errors++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        acc.op = in_ch.operation;
        acc.pos = in_ch.position;
        acc.ch = in_ch.character;
        acc.leds = in_ch.led_bits;
        case (acc.op)
          OP_TICK:   n_ticks++;
          OP_WRITE:  n_writes++;
          OP_COMMIT: n_commits++;
          default:   n_nops++;
        endcase
        // run the model even for pinned rows so its state stays in step
        scan_step(acc, res);
        beats_due.push_back(pin_now ? pin_beat : res);
      end
    end
  end

  // Receiver: stall ready at random, decided at each falling edge.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // Offer one beat from a falling edge, hold it until taken, return at the next falling edge.
  task automatic send_item(input scan_item_t it, input logic pinned, input scan_beat_t want);
    while ($urandom_range(0, 99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= it.op;
    in_ch.position <= it.pos;
    in_ch.character <= it.ch;
    in_ch.led_bits <= it.leds;
    pin_now = pinned;
    pin_beat = want;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Drop valid and hold off until every owed result beat has come back.
  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (beats_due.size() != 0);
    @(negedge clk);
  endtask

  function automatic drill_row_t row(input logic [OP_W-1:0] op, input int pos,
                                     input logic [7:0] ch, input logic [LED_W-1:0] leds,
                                     input int reps, input logic pinned = 1'b0,
                                     input logic pending = 1'b0);
    drill_row_t r;
    r.item.op = op;
    r.item.pos = pos[POS_W-1:0];
    r.item.ch = ch;
    r.item.leds = leds;
    r.reps = reps[7:0];
    r.pinned = pinned;
    // pinned rows all sit in the dark first slot, so the lines are still zero
    r.want.anode = '0;
    r.want.seg = '0;
    r.want.pending = pending;
    return r;
  endfunction

  function automatic scan_item_t random_item();
    scan_item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) it.op = OP_TICK;
    else if (pick < 80) it.op = OP_WRITE;
    else if (pick < 93) it.op = OP_COMMIT;
    else it.op = OP_NOP;
    // mostly real text digits, now and then a position the block must drop
    it.pos = ($urandom_range(0, 9) < 8) ? POS_W'($urandom_range(0, 4))
                                         : POS_W'($urandom_range(5, 7));
    if ($urandom_range(0, 1) == 1)
      it.ch = glyph_chars[$urandom_range(0, glyph_chars.len() - 1)];
    else
      it.ch = CHAR_W'($urandom_range(0, 255));
    it.leds = LED_W'($urandom_range(0, 8191));
    return it;
  endfunction

  initial begin : stimulus
    drill_row_t drill[$];
    scan_item_t it;
    int sent;
    logic pressed;

    // known levels everywhere before the first edge
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_TICK;
    in_ch.position = '0;
    in_ch.character = '0;
    in_ch.led_bits = '0;
    pin_now = 1'b0;
    pin_beat = '0;
    send_idle = 0;
    recv_idle = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: brightness stays at its reset value of zero.
    // first slot after reset is dark; all lines read zero
    drill.push_back(row(OP_TICK, 0, 8'h00, 13'h0000, 1, 1'b1));
    // undefined operation with every field bit high: no state change
    drill.push_back(row(OP_NOP, 7, 8'hff, 13'h1fff, 1, 1'b1));
    drill.push_back(row(OP_WRITE, 0, "8", 13'h0000, 1, 1'b1));
    drill.push_back(row(OP_WRITE, 4, "H", 13'h0000, 1, 1'b1));
    // position of the LED digit and the top position: both dropped
    drill.push_back(row(OP_WRITE, 5, "A", 13'h0000, 1, 1'b1));
    drill.push_back(row(OP_WRITE, 7, 8'h00, 13'h0000, 1, 1'b1));
    // code without a pattern turns into the underscore
    drill.push_back(row(OP_WRITE, 1, 8'hff, 13'h0000, 1, 1'b1));
    drill.push_back(row(OP_WRITE, 2, "c", 13'h0000, 1, 1'b1));
    drill.push_back(row(OP_WRITE, 3, "-", 13'h0000, 1, 1'b1));
    // all LED and dot bits on; frame now pending
    drill.push_back(row(OP_COMMIT, 0, 8'h00, 13'h1fff, 1, 1'b1, 1'b1));
    // finish the slot, then cross the digit boundary where the swap happens
    drill.push_back(row(OP_TICK, 0, 8'h00, 13'h0000, 7));
    drill.push_back(row(OP_TICK, 6, 8'h5a, 13'h0aaa, 1));
    // staging now holds the old shown frame; overwrite one digit, clear all LED bits
    drill.push_back(row(OP_WRITE, 0, "0", 13'h0000, 1));
    drill.push_back(row(OP_COMMIT, 0, 8'h00, 13'h0000, 1));
    drill.push_back(row(OP_TICK, 0, 8'h00, 13'h0000, 8));
    drill.push_back(row(OP_COMMIT, 3, "O", 13'h0aa5, 1));
    foreach (drill[r]) begin
      repeat (drill[r].reps) send_item(drill[r].item, drill[r].pinned, drill[r].want);
    end
    pin_now = 1'b0;
    hold_until_drained();

    // Random part: one brightness per phase, idle mix changes every two phases.
    for (int p = 0; p < PHASES; p++) begin
      if (p < 2) begin
        send_idle = 27;
        recv_idle = 83;
      end else if (p < 4) begin
        send_idle = 83;
        recv_idle = 27;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      // block is drained here, so the register may change
      cfg_we <= 1'b1;
      cfg_wdata <= BRIGHT_PLAN[p][BRIGHT_W-1:0];
      @(negedge clk);
      cfg_we <= 1'b0;
      sent = 0;
      pressed = 1'b0;
      while (sent < PHASE_ITEMS) begin
        // halfway through, pause the sender until every owed beat is back
        if (!pressed && sent >= PHASE_ITEMS / 2) begin
          hold_until_drained();
          pressed = 1'b1;
        end
        if ($urandom_range(0, 9) == 0) begin
          // whole frame: text digits 0..4 in order, then a commit
          for (int d = 0; d < NDIG - 1; d++) begin
            it = random_item();
            it.op = OP_WRITE;
            it.pos = POS_W'(d);
            send_item(it, 1'b0, '0);
          end
          it = random_item();
          it.op = OP_COMMIT;
          send_item(it, 1'b0, '0);
          sent += NDIG;
        end else begin
          send_item(random_item(), 1'b0, '0);
          sent++;
        end
      end
      hold_until_drained();
    end

    // let any stray beat show up before the verdict
    repeat (8) @(posedge clk);
    $display("Scan run: %0d beats in (%0d ticks, %0d writes, %0d commits, %0d undefined ops),",
             n_ticks + n_writes + n_commits + n_nops, n_ticks, n_writes, n_commits, n_nops);
    $display("  %0d result beats compared over %0d digit slots and %0d frame swaps.",
             n_checked, n_slots, n_swaps);
    if (n_errors == 0) begin
      $display("[seven_segment_scan_driver] OK");
    end else begin
      $display("[seven_segment_scan_driver] ERROR");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("[seven_segment_scan_driver] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
sv/sssd_pkg.sv
sv/sssd_if.sv
sv/seven_segment_scan_driver.sv
tb/seven_segment_scan_driver_tb.sv
